@@ sv/assert_macros.svh @@
// assertion macros used by the checker file aff2d_chk
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, masked while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also runs during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/aff2d_pkg.sv @@
`timescale 1ns / 1ps
// types, constants and helpers of the 2d affine matrix builder
// no dependencies
package aff2d_pkg;

  localparam int TABLE_LEN = 24;
  localparam int QUO_W     = 33;
  localparam int DIV_W     = 64;
  localparam int CRD_W     = 34;
  localparam int ANG_W     = 33;

  localparam logic signed [CRD_W-1:0] GAIN_Q30 = 34'sh026DD3B6A;
  localparam logic signed [31:0] SAT_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;
  localparam logic signed [63:0] SAT64_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT64_MIN = -64'sd2147483648;
  localparam logic [QUO_W-1:0] QUO_POS_LIM = 33'h07FFFFFFF;
  localparam logic [QUO_W-1:0] QUO_NEG_LIM = 33'h080000000;

  typedef struct packed {
    logic               func;
    logic signed [31:0] obj_scale_x;
    logic signed [31:0] obj_scale_y;
    logic signed [31:0] obj_pos_x;
    logic signed [31:0] obj_pos_y;
    logic        [15:0] obj_angle;
    logic signed [31:0] cam_scale_x;
    logic signed [31:0] cam_scale_y;
    logic signed [31:0] cam_pos_x;
    logic signed [31:0] cam_pos_y;
    logic        [15:0] cam_angle;
  } item_t;

  typedef struct packed {
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] m31;
    logic signed [31:0] m32;
  } mat_t;

  // one lane of the scale divider
  typedef struct packed {
    logic             neg;
    logic             zero;
    logic             ovf;
    logic [31:0]      den;
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_t;

  // cordic rotation state
  typedef struct packed {
    logic                    neg;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } crd_t;

  typedef struct packed {
    logic               rel;
    logic signed [31:0] osx;
    logic signed [31:0] osy;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    div_t               dx;
    div_t               dy;
    crd_t               crd;
  } pipe_t;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] c;
    logic signed [31:0] s;
    logic signed [31:0] ns;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
  } fin_t;

  typedef struct packed {
    logic signed [63:0] p11;
    logic signed [63:0] p12;
    logic signed [63:0] p21;
    logic signed [63:0] p22;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
  } prod_t;

  // arctangent of 2^-i as a 32-bit binary angle (full turn = 2^32)
  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] r;
    case (idx)
      0:       r = 32'h20000000;
      1:       r = 32'h12E4051E;
      2:       r = 32'h09FB385B;
      3:       r = 32'h051111D4;
      4:       r = 32'h028B0D43;
      5:       r = 32'h0145D7E1;
      6:       r = 32'h00A2F61E;
      7:       r = 32'h00517C55;
      8:       r = 32'h0028BE53;
      9:       r = 32'h00145F2F;
      10:      r = 32'h000A2F98;
      11:      r = 32'h000517CC;
      12:      r = 32'h00028BE6;
      13:      r = 32'h000145F3;
      14:      r = 32'h0000A2FA;
      15:      r = 32'h0000517D;
      16:      r = 32'h000028BE;
      17:      r = 32'h0000145F;
      18:      r = 32'h00000A30;
      19:      r = 32'h00000518;
      20:      r = 32'h0000028C;
      21:      r = 32'h00000146;
      22:      r = 32'h000000A3;
      23:      r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // clamp to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT64_MAX) begin
      r = SAT_MAX;
    end else if (v < SAT64_MIN) begin
      r = SAT_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/aff2d_prep.sv @@
`timescale 1ns / 1ps
// input stage: mode selection, translation, divider and cordic setup
// depends on aff2d_pkg
module aff2d_prep import aff2d_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  item_valid,
  input  item_t item,
  output logic  vld,
  output pipe_t q
);

  pipe_t nxt;

  // operand magnitudes and quotient sign for one scale lane
  function automatic div_t div_init(input logic signed [31:0] os,
                                    input logic signed [31:0] cs);
    logic signed [32:0] num;
    logic [32:0]        mag;
    logic [31:0]        dmag;
    div_t               d;
    num    = {os, 1'b0};
    mag    = num[32] ? 33'(-num) : 33'(num);
    dmag   = cs[31] ? 32'(-cs) : 32'(cs);
    d.neg  = num[32] ^ cs[31];
    d.zero = (mag == '0);
    d.ovf  = 1'b0;
    d.den  = dmag;
    d.rem  = DIV_W'(mag) << FRAC_BITS;
    d.quo  = '0;
    return d;
  endfunction

  // doubled position difference, saturated
  function automatic logic signed [31:0] rel_pos(input logic signed [31:0] op,
                                                 input logic signed [31:0] cp);
    logic signed [33:0] dbl;
    dbl = (34'(op) - 34'(cp)) <<< 1;
    return sat32(64'(dbl));
  endfunction

  // fold the angle into the right half plane
  logic [15:0] ang;
  logic [31:0] a32;
  logic        fold;
  logic [31:0] af;

  always_comb begin
    ang  = item.func ? 16'(item.obj_angle - item.cam_angle) : item.obj_angle;
    a32  = {ang, 16'h0};
    fold = a32[31] ^ a32[30];
    af   = {a32[31] ^ fold, a32[30:0]};

    nxt.rel     = item.func;
    nxt.osx     = item.obj_scale_x;
    nxt.osy     = item.obj_scale_y;
    nxt.tx      = item.func ? rel_pos(item.obj_pos_x, item.cam_pos_x) : item.obj_pos_x;
    nxt.ty      = item.func ? rel_pos(item.obj_pos_y, item.cam_pos_y) : item.obj_pos_y;
    nxt.dx      = div_init(item.obj_scale_x, item.cam_scale_x);
    nxt.dy      = div_init(item.obj_scale_y, item.cam_scale_y);
    nxt.crd.neg = fold;
    nxt.crd.x   = GAIN_Q30;
    nxt.crd.y   = '0;
    nxt.crd.z   = ANG_W'(signed'(af));
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

@@ sv/aff2d_iter.sv @@
`timescale 1ns / 1ps
// iteration stage: divider overflow check or quotient bit; cordic step if in range
// depends on aff2d_pkg
module aff2d_iter import aff2d_pkg::*; #(
  parameter int STAGE        = 1,
  parameter int CORDIC_STEPS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  vld_in,
  input  pipe_t d,
  output logic  vld,
  output pipe_t q
);

  // quotient bits are resolved from the top down, one per stage
  localparam int DIV_BIT = (STAGE >= 2) ? QUO_W + 1 - STAGE : 0;
  localparam int CRD_IDX = STAGE - 1;

  // quotient too large for 33 bits, zero divisor included
  function automatic div_t ovf_chk(input div_t v);
    div_t r;
    r     = v;
    r.ovf = ({1'b0, v.rem} >= {v.den, 33'h0});
    return r;
  endfunction

  // restoring step for one quotient bit
  function automatic div_t div_bit(input div_t v);
    logic [DIV_W-1:0] sh;
    div_t             r;
    r  = v;
    sh = DIV_W'(v.den) << DIV_BIT;
    if (v.rem >= sh) begin
      r.rem          = v.rem - sh;
      r.quo[DIV_BIT] = 1'b1;
    end
    return r;
  endfunction

  // one cordic micro-rotation
  function automatic crd_t crd_step(input crd_t v);
    logic signed [CRD_W-1:0] dxs;
    logic signed [CRD_W-1:0] dys;
    logic signed [ANG_W-1:0] at;
    crd_t                    r;
    r   = v;
    dxs = v.y >>> CRD_IDX;
    dys = v.x >>> CRD_IDX;
    at  = signed'({1'b0, atan_q30(CRD_IDX)});
    if (!v.z[ANG_W-1]) begin
      r.x = v.x - dxs;
      r.y = v.y + dys;
      r.z = v.z - at;
    end else begin
      r.x = v.x + dxs;
      r.y = v.y - dys;
      r.z = v.z + at;
    end
    return r;
  endfunction

  pipe_t nxt;

  always_comb begin
    nxt = d;
    if (STAGE == 1) begin
      nxt.dx = ovf_chk(d.dx);
      nxt.dy = ovf_chk(d.dy);
    end else begin
      nxt.dx = div_bit(d.dx);
      nxt.dy = div_bit(d.dy);
    end
    if (CRD_IDX < CORDIC_STEPS && CRD_IDX < TABLE_LEN) begin
      nxt.crd = crd_step(d.crd);
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

@@ sv/aff2d_fin.sv @@
`timescale 1ns / 1ps
// finishing stage: quotient sign and saturation, sine and cosine rounding
// depends on aff2d_pkg
module aff2d_fin import aff2d_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  vld_in,
  input  pipe_t d,
  output logic  vld,
  output fin_t  q
);

  localparam int RSH = 30 - FRAC_BITS;
  localparam logic signed [CRD_W-1:0] HALF = CRD_W'(1) <<< (RSH - 1);

  // signed, saturated quotient
  function automatic logic signed [31:0] quo_sat(input div_t v);
    logic [QUO_W-1:0]   nq;
    logic signed [31:0] r;
    nq = -v.quo;
    if (v.zero) begin
      r = '0;
    end else if (v.ovf) begin
      r = v.neg ? SAT_MIN : SAT_MAX;
    end else if (!v.neg) begin
      r = (v.quo > QUO_POS_LIM) ? SAT_MAX : signed'(v.quo[31:0]);
    end else begin
      r = (v.quo > QUO_NEG_LIM) ? SAT_MIN : signed'(nq[31:0]);
    end
    return r;
  endfunction

  // undo the half turn, then round to the output fraction
  function automatic logic signed [31:0] crd_round(input logic signed [CRD_W-1:0] v,
                                                   input logic neg);
    logic signed [CRD_W-1:0] vf;
    logic signed [CRD_W-1:0] vr;
    vf = neg ? -v : v;
    vr = (vf + HALF) >>> RSH;
    return vr[31:0];
  endfunction

  fin_t nxt;

  always_comb begin
    nxt.sx = d.rel ? quo_sat(d.dx) : d.osx;
    nxt.sy = d.rel ? quo_sat(d.dy) : d.osy;
    nxt.c  = crd_round(d.crd.x, d.crd.neg);
    nxt.s  = crd_round(d.crd.y, d.crd.neg);
    nxt.ns = -crd_round(d.crd.y, d.crd.neg);
    nxt.tx = d.tx;
    nxt.ty = d.ty;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

@@ sv/aff2d_mul.sv @@
`timescale 1ns / 1ps
// scale by sine and cosine: product stage, then rounding and saturation stage
// depends on aff2d_pkg
module aff2d_mul import aff2d_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vld_in,
  input  fin_t d,
  output logic vld,
  output mat_t q
);

  localparam logic signed [63:0] HALF = 64'(1) <<< (FRAC_BITS - 1);

  function automatic logic signed [31:0] round_sat(input logic signed [63:0] p);
    logic signed [63:0] r;
    r = (p + HALF) >>> FRAC_BITS;
    return sat32(r);
  endfunction

  prod_t prod;
  prod_t prod_next;
  logic  pvld;
  mat_t  mat_next;

  // four 32x32 products
  always_comb begin
    prod_next.p11 = d.sx * d.c;
    prod_next.p12 = d.sx * d.ns;
    prod_next.p21 = d.sy * d.s;
    prod_next.p22 = d.sy * d.c;
    prod_next.tx  = d.tx;
    prod_next.ty  = d.ty;
  end

  // rounding and saturation to the output fraction
  always_comb begin
    mat_next.m11 = round_sat(prod.p11);
    mat_next.m12 = round_sat(prod.p12);
    mat_next.m21 = round_sat(prod.p21);
    mat_next.m22 = round_sat(prod.p22);
    mat_next.m31 = prod.tx;
    mat_next.m32 = prod.ty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvld <= 1'b0;
      vld  <= 1'b0;
    end else if (en) begin
      pvld <= vld_in;
      vld  <= pvld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
      q    <= mat_next;
    end
  end

endmodule

@@ sv/affine2d_transform_matrix_builder.sv @@
`timescale 1ns / 1ps
// 2d affine matrix builder: scale, rotate, translate, optional camera-relative mode
// pipelined: one item per cycle sustained while no waiting result holds the pipeline
// depth set by the 33-bit restoring divider (one quotient bit a stage) plus setup,
// rounding and the two multiplier stages; cordic steps run alongside the divider
// a waiting result freezes the whole pipeline; rst (synchronous) clears all valid bits
// depends on aff2d_pkg, aff2d_prep, aff2d_iter, aff2d_fin, aff2d_mul
module affine2d_transform_matrix_builder import aff2d_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  output logic  mat_valid,
  input  logic  mat_stall,
  output mat_t  mat
);

  localparam int N_ITER = QUO_W + 1;

  logic          en;
  logic [N_ITER:0] pvld;
  pipe_t         pipe [N_ITER+1];
  logic          fvld;
  fin_t          fin;

  // whole pipeline advances unless the result register is held
  assign item_stall = mat_valid & mat_stall;
  assign en         = ~item_stall;

  aff2d_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .item_valid (item_valid),
    .item       (item),
    .vld        (pvld[0]),
    .q          (pipe[0])
  );

  // divider and cordic iterations
  for (genvar k = 1; k <= N_ITER; k++) begin : g_iter
    aff2d_iter #(.STAGE(k), .CORDIC_STEPS(CORDIC_STEPS)) u_iter (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .vld_in (pvld[k-1]),
      .d      (pipe[k-1]),
      .vld    (pvld[k]),
      .q      (pipe[k])
    );
  end

  aff2d_fin #(.FRAC_BITS(FRAC_BITS)) u_fin (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vld_in (pvld[N_ITER]),
    .d      (pipe[N_ITER]),
    .vld    (fvld),
    .q      (fin)
  );

  aff2d_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vld_in (fvld),
    .d      (fin),
    .vld    (mat_valid),
    .q      (mat)
  );

endmodule

@@ sv/aff2d_chk.sv @@
`timescale 1ns / 1ps
// port-level checks of the matrix builder, bound to the top level
// depends on aff2d_pkg and assert_macros.svh
`include "assert_macros.svh"

module aff2d_chk import aff2d_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  item_stall,
  input logic  mat_valid,
  input logic  mat_stall,
  input mat_t  mat
);

  // no result right after reset
  `ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !mat_valid, "result valid after reset")

  // input held back only by a waiting result
  `ASSERT_CLK(a_stall_src, clk, rst, item_stall |-> (mat_valid && mat_stall), "bad stall")

  // a held result stays put
  `ASSERT_CLK(a_out_hold, clk, rst, (mat_valid && mat_stall) |=> (mat_valid && $stable(mat)), "held result changed")

  // after a result transfer, the input side is stalled only while a new result is valid
  `ASSERT_CLK(a_stall_free, clk, rst, (mat_valid && !mat_stall) |=> !item_stall || mat_valid, "stall held")

endmodule

bind affine2d_transform_matrix_builder aff2d_chk u_chk (.*);
